@@ rtl/core/ittl_pkg.sv @@
package ittl_pkg;

	// Time width and how many DONE frames close one of our turns
	localparam int TIME_BITS    = 32;
	localparam int DONE_REPEATS = 3;
	localparam int DL_BITS      = $clog2(DONE_REPEATS + 1);

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [DL_BITS-1:0]   done_cnt_t;

	// Frame commands
	localparam logic [7:0] CMD_HELLO  = 8'h01;
	localparam logic [7:0] CMD_ACTIVE = 8'h11;
	localparam logic [7:0] CMD_DONE   = 8'h12;

	localparam logic [7:0] HELLO_RUN_MAX = 8'hFF;

	// talk_state codes on the result
	localparam logic [1:0] TALK_IDLE    = 2'd0;
	localparam logic [1:0] TALK_PARTNER = 2'd1;
	localparam logic [1:0] TALK_SELF    = 2'd2;

	// Register indexes
	typedef enum logic [2:0] {
		REG_SELF_ID         = 3'd0,
		REG_PARTNER_ID      = 3'd1,
		REG_HELLO_GAP       = 3'd2,
		REG_HANDSHAKE_COUNT = 3'd3,
		REG_ACK_DELAY       = 3'd4,
		REG_LOST_TIMEOUT    = 3'd5,
		REG_TURN_TIMEOUT    = 3'd6,
		REG_ACTIVE_INTERVAL = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  self_id;
		logic [7:0]  partner_id;
		logic [15:0] hello_gap_ms;
		logic [7:0]  handshake_count;
		logic [15:0] ack_delay_ms;
		logic [15:0] lost_timeout_ms;
		logic [15:0] turn_timeout_ms;
		logic [15:0] active_interval_ms;
	} cfg_t;

	typedef struct packed {
		logic        action;
		logic [31:0] now_ms;
		logic        frame_is_nec;
		logic [15:0] frame_address;
		logic [7:0]  frame_command;
		logic [10:0] talk_duration_ms;
	} item_t;

	typedef struct packed {
		logic       send_ack;
		logic       send_active;
		logic       send_done;
		logic [1:0] talk_state;
		logic       handshake_done;
	} res_t;

	// Elapsed time, wraps at TIME_BITS
	function automatic time_t tdiff(input time_t a, input time_t b);
		return a - b;
	endfunction

endpackage

@@ rtl/core/ir_turn_taking_link_controller.sv @@
// IR turn-taking link controller, child side.
// Input channel (in_valid/in_ready): one request per millisecond tick, carrying
// now_ms and, when action is set, a received frame (NEC flag, address, command)
// plus the random talk length for a turn that would start on this tick.
// Output channel (out_valid/out_ready): exactly one result per request: the
// ACK / ACTIVE / DONE transmit strobes in that order, talk_state and the
// handshake flag as they stand after the tick.
// Config: cfg_we writes cfg_wdata into register cfg_index
// (0 self_id, 1 partner_id, 2 hello gap, 3 handshake count, 4 ack delay,
// 5 lost timeout, 6 turn timeout, 7 active interval); write only while idle.
// Path: an accepted request is registered in the input stage, then its result
// in the result register, where out_valid rises.
// Throughput: one request per cycle unless stalled; the whole state update is a
// single pass of compares and subtracts from input stage to result register.
// Reset: arst_n clears the conversation to idle, all timestamps to unset and
// the registers to their defaults; no request is pending afterwards.
// Stall: while a result waits, one more request is still taken into the input
// stage; in_ready drops only when both stages are full.
module ir_turn_taking_link_controller (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [31:0] now_ms,
	input  logic        frame_is_nec,
	input  logic [15:0] frame_address,
	input  logic [7:0]  frame_command,
	input  logic [10:0] talk_duration_ms,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        send_ack,
	output logic        send_active,
	output logic        send_done,
	output logic [1:0]  talk_state,
	output logic        handshake_done
);

	ittl_pkg::cfg_t  cfg;
	ittl_pkg::item_t item_s1;
	ittl_pkg::res_t  res;
	ittl_pkg::res_t  res_q;
	logic            vld_s1;
	logic            out_vld_q;
	logic            adv;

	// the input stage moves on whenever the result register is free or draining
	assign adv      = vld_s1 && (!out_vld_q || out_ready);
	assign in_ready = !vld_s1 || adv;

	ittl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	// request payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.action           <= action;
			item_s1.now_ms           <= now_ms;
			item_s1.frame_is_nec     <= frame_is_nec;
			item_s1.frame_address    <= frame_address;
			item_s1.frame_command    <= frame_command;
			item_s1.talk_duration_ms <= talk_duration_ms;
		end
	end

	ittl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.adv    (adv),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_vld_q;
	assign send_ack       = res_q.send_ack;
	assign send_active    = res_q.send_active;
	assign send_done      = res_q.send_done;
	assign talk_state     = res_q.talk_state;
	assign handshake_done = res_q.handshake_done;

endmodule

@@ rtl/core/ittl_cfg.sv @@
module ittl_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_wdata,
	output ittl_pkg::cfg_t      cfg
);

	ittl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.self_id            <= 8'd2;
			cfg_q.partner_id         <= 8'd1;
			cfg_q.hello_gap_ms       <= 16'd250;
			cfg_q.handshake_count    <= 8'd3;
			cfg_q.ack_delay_ms       <= 16'd80;
			cfg_q.lost_timeout_ms    <= 16'd2000;
			cfg_q.turn_timeout_ms    <= 16'd10000;
			cfg_q.active_interval_ms <= 16'd150;
		end else if (cfg_we) begin
			case (ittl_pkg::reg_idx_t'(cfg_index))
				ittl_pkg::REG_SELF_ID:         cfg_q.self_id            <= cfg_wdata[7:0];
				ittl_pkg::REG_PARTNER_ID:      cfg_q.partner_id         <= cfg_wdata[7:0];
				ittl_pkg::REG_HELLO_GAP:       cfg_q.hello_gap_ms       <= cfg_wdata;
				ittl_pkg::REG_HANDSHAKE_COUNT: cfg_q.handshake_count    <= cfg_wdata[7:0];
				ittl_pkg::REG_ACK_DELAY:       cfg_q.ack_delay_ms       <= cfg_wdata;
				ittl_pkg::REG_LOST_TIMEOUT:    cfg_q.lost_timeout_ms    <= cfg_wdata;
				ittl_pkg::REG_TURN_TIMEOUT:    cfg_q.turn_timeout_ms    <= cfg_wdata;
				ittl_pkg::REG_ACTIVE_INTERVAL: cfg_q.active_interval_ms <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/ittl_core.sv @@
module ittl_core (
	input  logic             clk,
	input  logic             arst_n,
	input  ittl_pkg::cfg_t   cfg,
	input  ittl_pkg::item_t  item,
	input  logic             adv,
	output ittl_pkg::res_t   res
);

	typedef enum logic [2:0] {
		ST_IDLE    = 3'b001,
		ST_PARTNER = 3'b010,
		ST_SELF    = 3'b100
	} conv_t;

	typedef struct packed {
		conv_t                conv;
		logic                 hs;
		logic [7:0]           hello_run;
		ittl_pkg::time_t      last_hello;
		ittl_pkg::time_t      ack_due;
		ittl_pkg::time_t      last_partner;
		ittl_pkg::time_t      entered;
		ittl_pkg::time_t      partner_turn;
		ittl_pkg::time_t      last_active;
		ittl_pkg::time_t      turn_end;
		ittl_pkg::time_t      last_done;
		ittl_pkg::done_cnt_t  done_left;
	} st_t;

	st_t st_q;
	st_t nx;

	// Session drop: everything but the HELLO timestamp
	function automatic st_t sess_clear(input st_t s);
		st_t r;
		r              = '0;
		r.conv         = ST_IDLE;
		r.last_hello   = s.last_hello;
		return r;
	endfunction

	always_comb begin
		ittl_pkg::time_t now;
		ittl_pkg::time_t lost;
		logic [7:0]      src;
		logic [7:0]      dst;
		logic            frame_ok;
		logic            ack;
		logic            act;
		logic            done;

		now  = ittl_pkg::time_t'(item.now_ms);
		lost = ittl_pkg::time_t'(cfg.lost_timeout_ms);
		src  = item.frame_address[15:8];
		dst  = item.frame_address[7:0];
		// own echo is dropped before the address match
		frame_ok = item.action && item.frame_is_nec
			&& !(src == cfg.self_id && dst == cfg.partner_id)
			&& src == cfg.partner_id && dst == cfg.self_id;
		ack  = 1'b0;
		act  = 1'b0;
		done = 1'b0;
		nx   = st_q;

		if (frame_ok) begin
			case (item.frame_command)
				ittl_pkg::CMD_HELLO: begin
					if (nx.conv != ST_IDLE) begin
						nx = sess_clear(nx);
					end
					if (nx.last_hello != '0 && ittl_pkg::tdiff(now, nx.last_hello)
						<= ittl_pkg::time_t'(cfg.hello_gap_ms)) begin
						if (nx.hello_run != ittl_pkg::HELLO_RUN_MAX) begin
							nx.hello_run = nx.hello_run + 8'd1;
						end
					end else begin
						nx.hello_run = 8'd1;
					end
					nx.last_hello = now;
					nx.ack_due    = now + ittl_pkg::time_t'(cfg.ack_delay_ms);
					if (!nx.hs && nx.hello_run >= cfg.handshake_count) begin
						nx.hs = 1'b1;
					end
				end
				ittl_pkg::CMD_ACTIVE: begin
					nx.hs = 1'b1;
					if (nx.conv != ST_PARTNER) begin
						nx.conv    = ST_PARTNER;
						nx.entered = now;
					end
					if (nx.partner_turn == '0) begin
						nx.partner_turn = now;
					end
					nx.last_partner = now;
				end
				ittl_pkg::CMD_DONE: begin
					nx.hs           = 1'b1;
					nx.last_partner = now;
					if (nx.conv != ST_SELF) begin
						nx.partner_turn = '0;
						nx.last_partner = '0;
						nx.last_done    = '0;
						nx.done_left    = '0;
						nx.last_active  = '0;
						nx.turn_end     = now + ittl_pkg::time_t'(item.talk_duration_ms);
						nx.conv         = ST_SELF;
						nx.entered      = now;
					end
				end
				default: ;
			endcase
		end

		if (nx.ack_due != '0 && now >= nx.ack_due) begin
			ack        = 1'b1;
			nx.ack_due = '0;
		end

		// HELLO run lost while idle
		if (nx.conv == ST_IDLE && nx.hs && nx.last_hello != '0
			&& ittl_pkg::tdiff(now, nx.last_hello) > lost) begin
			nx.hs         = 1'b0;
			nx.hello_run  = 8'd0;
			nx.last_hello = '0;
		end

		case (nx.conv)
			ST_SELF: begin
				if (nx.last_active == '0 || ittl_pkg::tdiff(now, nx.last_active)
					>= ittl_pkg::time_t'(cfg.active_interval_ms)) begin
					act            = 1'b1;
					nx.last_active = now;
				end
				if (nx.turn_end != '0 && now >= nx.turn_end) begin
					done            = 1'b1;
					nx.last_done    = now;
					nx.done_left    = ittl_pkg::done_cnt_t'(ittl_pkg::DONE_REPEATS - 1);
					nx.turn_end     = '0;
					nx.last_active  = '0;
					nx.last_partner = '0;
					nx.partner_turn = '0;
					nx.conv         = ST_PARTNER;
					nx.entered      = now;
				end
			end
			ST_PARTNER: begin
				if (nx.partner_turn == '0) begin
					if (nx.entered != '0 && ittl_pkg::tdiff(now, nx.entered) > lost) begin
						nx = sess_clear(nx);
					end
				end else if (ittl_pkg::tdiff(now, nx.last_partner) > lost) begin
					nx = sess_clear(nx);
				end else if (ittl_pkg::tdiff(now, nx.partner_turn)
					> ittl_pkg::time_t'(cfg.turn_timeout_ms)) begin
					nx = sess_clear(nx);
				end
				// DONE repeats until the partner answers or the repeats run out
				if (nx.conv == ST_PARTNER && nx.partner_turn == '0 && nx.done_left != '0
					&& ittl_pkg::tdiff(now, nx.last_done)
					>= ittl_pkg::time_t'(cfg.active_interval_ms)) begin
					done         = 1'b1;
					nx.last_done = now;
					nx.done_left = nx.done_left - ittl_pkg::done_cnt_t'(1);
				end
			end
			default: ;
		endcase

		res.send_ack       = ack;
		res.send_active    = act;
		res.send_done      = done;
		res.handshake_done = nx.hs;
		case (nx.conv)
			ST_PARTNER: res.talk_state = ittl_pkg::TALK_PARTNER;
			ST_SELF:    res.talk_state = ittl_pkg::TALK_SELF;
			default:    res.talk_state = ittl_pkg::TALK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= sess_clear(st_t'('0));
		end else if (adv) begin
			st_q <= nx;
		end
	end

`ifndef SYNTH
	// outside idle the handshake flag is always set
	a_hs_when_talking: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.conv != ST_IDLE |-> st_q.hs)
		else $error("talking without handshake");

	// pending DONE repeats only exist in the partner state
	a_done_left_partner: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.done_left != '0 |-> st_q.conv == ST_PARTNER)
		else $error("DONE repeats outside partner state");

	// a sent DONE always hands the turn away
	a_done_leaves_self: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.send_done |=> st_q.conv == ST_PARTNER)
		else $error("DONE sent but turn kept");
`endif

endmodule
